[rtl/core/zscp_pkg.sv]
// ----------------------------------------------------------------------------
// zscp_pkg
// Shared types, constants and helpers of the spectator-plane centroid block.
// ----------------------------------------------------------------------------
package zscp_pkg;

    // Geometry and field widths
    localparam int ENERGY_BITS_DEF = 16;
    localparam int TOWERS          = 4;
    localparam int SIDES           = 2;
    localparam int LANE_W          = 16;
    localparam int MAG_W           = 15;
    localparam int LSUM_W          = MAG_W + 2;
    localparam int WEIGHT_W        = 25;
    localparam int WSUM_W          = WEIGHT_W + 2;
    localparam int DMAG_W          = WEIGHT_W + 1;
    localparam int CF_W            = 17;
    localparam int Q_W             = 16;
    localparam int PROD_W          = CF_W + DMAG_W;

    // Power weight pipeline
    localparam int LOG_FRAC   = 16;
    localparam int SQ_STEPS   = 16;
    localparam int EXP_STEPS  = 12;
    localparam int LANE_LAT   = 1 + SQ_STEPS + 1 + EXP_STEPS + 1;

    // Dividers
    localparam int CF_NUM_W   = 31;
    localparam int CF_DEN_W   = 26;
    localparam int CF_QUO_W   = 16;
    localparam int CEN_NUM_W  = 40;
    localparam int CEN_QUO_W  = 15;
    localparam int MERGE_LAT  = 1 + CF_QUO_W + 1 + 1 + CEN_QUO_W + 1;
    localparam int TOTAL_LAT  = LANE_LAT + MERGE_LAT;

    // Arithmetic constants (Q.16 unless noted)
    localparam logic [14:0] ALPHA_Q16   = 15'd25887;
    localparam logic [16:0] ONE_Q16     = 17'd65536;
    localparam logic [16:0] CF_BASE_Q16 = 17'd124098;
    localparam logic [30:0] CF_NUM      = 31'd2050655330;
    localparam logic [14:0] CF_OFS_Q8   = 15'd31522;

    // 2^(2^-k) for k = 1..12
    localparam logic [16:0] EXP2_FRAC [EXP_STEPS] = '{
        17'd92682, 17'd77935, 17'd71468, 17'd68438, 17'd66971, 17'd66250,
        17'd65892, 17'd65714, 17'd65625, 17'd65580, 17'd65558, 17'd65547
    };

    // Reject stage codes
    localparam logic [3:0] RJ_NO_ZDC    = 4'd0;
    localparam logic [3:0] RJ_COMMON    = 4'd1;
    localparam logic [3:0] RJ_SECTOR_A  = 4'd2;
    localparam logic [3:0] RJ_SECTOR_C  = 4'd3;
    localparam logic [3:0] RJ_QUALITY   = 4'd4;
    localparam logic [3:0] RJ_ZVTX      = 4'd5;
    localparam logic [3:0] RJ_CUTS      = 4'd6;
    localparam logic [3:0] RJ_SMALL_SUM = 4'd7;
    localparam logic [3:0] RJ_ACCEPTED  = 4'd8;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_VAL_W = 15;
    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_CUT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENT_MIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENT_MAX    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REQ_QUALITY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REQ_ZVTX    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_WT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEC_CORR   = 3'd6;

    typedef struct packed {
        logic [6:0]         event_flags;
        logic [13:0]        centrality;
        logic signed [15:0] vertex_z;
        logic signed [15:0] side_a_common;
        logic signed [15:0] side_c_common;
        logic [63:0]        side_a_sectors;
        logic [63:0]        side_c_sectors;
    } event_t;

    typedef struct packed {
        logic               accepted;
        logic [3:0]         reject_stage;
        logic signed [15:0] side_a_qx;
        logic signed [15:0] side_c_qx;
        logic signed [15:0] side_a_qy;
        logic signed [15:0] side_c_qy;
    } result_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_VAL_W-1:0] value;
    } cfg_write_t;

    // Merge stage result: signed centroids per side (0 = A, 1 = C)
    typedef struct packed {
        logic                     sum_zero;
        logic [SIDES-1:0][Q_W-1:0] qx;
        logic [SIDES-1:0][Q_W-1:0] qy;
    } merge_out_t;

    // Index of the leading one, zero for an empty word
    function automatic logic [3:0] lead_one(input logic [MAG_W-1:0] e);
        logic [3:0] p;
        p = '0;
        for (int i = 1; i < MAG_W; i++) begin
            if (e[i]) begin
                p = 4'(i);
            end
        end
        return p;
    endfunction

endpackage

[rtl/core/zscp_stream_if.sv]
// ----------------------------------------------------------------------------
// zscp_stream_if
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface zscp_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/zscp_divider.sv]
// ----------------------------------------------------------------------------
// zscp_divider
// Pipelined restoring divider, one quotient bit per stage.
// The quotient must fit QUO_W bits.
// ----------------------------------------------------------------------------
module zscp_divider #(
    parameter int NUM_W = 40,
    parameter int DEN_W = 27,
    parameter int QUO_W = 15
) (
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QUO_W-1:0] quo
);
    localparam int CMP_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

    logic [NUM_W-1:0] rem_reg [QUO_W];
    logic [DEN_W-1:0] den_reg [QUO_W];
    logic [QUO_W-1:0] quo_reg [QUO_W];

    for (genvar i = 0; i < QUO_W; i++) begin : g_stage
        localparam int SH = QUO_W - 1 - i;
        logic [NUM_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [QUO_W-1:0] quo_in;
        logic [CMP_W-1:0] trial;
        logic             take;
        logic [NUM_W-1:0] rem_next;
        logic [QUO_W-1:0] quo_next;

        if (i == 0) begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
        end else begin : g_rest
            assign rem_in = rem_reg[i-1];
            assign den_in = den_reg[i-1];
            assign quo_in = quo_reg[i-1];
        end

        // Try subtracting the shifted divisor
        always_comb
        begin
            trial    = CMP_W'(den_in) << SH;
            take     = CMP_W'(rem_in) >= trial;
            rem_next = take ? NUM_W'(CMP_W'(rem_in) - trial) : rem_in;
            quo_next = {quo_in[QUO_W-2:0], take};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= rem_next;
                den_reg[i] <= den_in;
                quo_reg[i] <= quo_next;
            end
        end
    end

    assign quo = quo_reg[QUO_W-1];

endmodule

[rtl/core/zscp_power_lane.sv]
// ----------------------------------------------------------------------------
// zscp_power_lane
// One sector lane: energy to weight, optionally energy^0.395 through a
// squaring log2 and a product-of-constants exp2.
// ----------------------------------------------------------------------------
module zscp_power_lane (
    input  logic                           clk,
    input  logic                           en,
    input  logic                           power_weighting,
    input  logic [zscp_pkg::MAG_W-1:0]     energy,
    output logic [zscp_pkg::WEIGHT_W-1:0]  weight
);
    import zscp_pkg::*;

    localparam int X_W   = 16;
    localparam int LOG_W = 4 + LOG_FRAC;
    localparam int LP_W  = 19;
    localparam int R_W   = 18;
    localparam int SC_W  = LOG_W + 16;

    logic [3:0]       lead;
    logic [X_W-1:0]   x_first;

    logic [X_W-1:0]   x_reg  [SQ_STEPS+1];
    logic [LOG_W-1:0] l_reg  [SQ_STEPS+1];
    logic [MAG_W-1:0] es_reg [SQ_STEPS+1];

    logic [LP_W-1:0]  lp_reg [EXP_STEPS+1];
    logic [R_W-1:0]   r_reg  [EXP_STEPS+1];
    logic [MAG_W-1:0] ex_reg [EXP_STEPS+1];

    logic [SC_W-1:0]     scaled;
    logic [WEIGHT_W-1:0] weight_next;
    logic [WEIGHT_W-1:0] weight_reg;

    // Normalize mantissa to Q1.15
    always_comb
    begin
        lead    = lead_one(energy);
        x_first = X_W'({1'b0, energy} << (4'd15 - lead));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]  <= x_first;
            l_reg[0]  <= {lead, {LOG_FRAC{1'b0}}};
            es_reg[0] <= energy;
        end
    end

    // One log2 fraction bit per squaring stage
    for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sq
        logic [2*X_W-1:0] sq;
        logic [X_W:0]     t;
        logic [X_W-1:0]   x_next;
        logic [LOG_W-1:0] l_next;

        always_comb
        begin
            sq     = (2*X_W)'(x_reg[i]) * (2*X_W)'(x_reg[i]);
            t      = sq[X_W+15:15];
            x_next = t[X_W] ? t[X_W:1] : t[X_W-1:0];
            l_next = l_reg[i];
            if (t[X_W])
            begin
                l_next[LOG_FRAC-1-i] = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i+1]  <= x_next;
                l_reg[i+1]  <= l_next;
                es_reg[i+1] <= es_reg[i];
            end
        end
    end

    // Scale log by the exponent, rounded
    assign scaled = SC_W'(l_reg[SQ_STEPS]) * SC_W'(ALPHA_Q16) + SC_W'(32768);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lp_reg[0] <= scaled[LP_W+15:16];
            r_reg[0]  <= R_W'(ONE_Q16);
            ex_reg[0] <= es_reg[SQ_STEPS];
        end
    end

    // Multiply in 2^(2^-k) for each set fraction bit
    for (genvar i = 0; i < EXP_STEPS; i++) begin : g_exp
        localparam int PW = R_W + 18;
        logic [PW-1:0]  prod;
        logic [R_W-1:0] r_next;

        always_comb
        begin
            prod   = PW'(r_reg[i]) * PW'(EXP2_FRAC[i]) + PW'(32768);
            r_next = lp_reg[i][LOG_FRAC-1-i] ? prod[R_W+15:16] : r_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[i+1]  <= r_next;
                lp_reg[i+1] <= lp_reg[i];
                ex_reg[i+1] <= ex_reg[i];
            end
        end
    end

    // Apply integer part, or pass the linear energy
    always_comb
    begin
        if (power_weighting)
        begin
            weight_next = WEIGHT_W'(r_reg[EXP_STEPS]) << lp_reg[EXP_STEPS][LP_W-1:LOG_FRAC];
        end
        else
        begin
            weight_next = WEIGHT_W'(ex_reg[EXP_STEPS]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            weight_reg <= weight_next;
        end
    end

    assign weight = weight_reg;

endmodule

[rtl/core/zscp_merge.sv]
// ----------------------------------------------------------------------------
// zscp_merge
// Combines the lane weights per side: weight sum and differences, spectator
// correction factor, and the centroid divisions with sign.
// ----------------------------------------------------------------------------
module zscp_merge (
    input  logic                                                  clk,
    input  logic                                                  en,
    input  logic                                                  spectator_correction,
    input  logic [zscp_pkg::SIDES-1:0][zscp_pkg::TOWERS-1:0][zscp_pkg::WEIGHT_W-1:0] weights,
    input  logic [zscp_pkg::SIDES-1:0][zscp_pkg::LSUM_W-1:0]     lin_sums,
    output zscp_pkg::merge_out_t                                  result
);
    import zscp_pkg::*;

    typedef struct packed {
        logic [WSUM_W-1:0] wsum;
        logic [DMAG_W-1:0] xmag;
        logic [DMAG_W-1:0] ymag;
        logic              xneg;
        logic              yneg;
        logic              zero;
    } side_t;

    typedef struct packed {
        logic [PROD_W-1:0] px;
        logic [PROD_W-1:0] py;
        logic [WSUM_W-1:0] wsum;
        logic              xneg;
        logic              yneg;
        logic              zero;
    } prod_t;

    typedef struct packed {
        logic xneg;
        logic yneg;
        logic zero;
    } sign_t;

    logic [SIDES-1:0] zero_out;

    for (genvar s = 0; s < SIDES; s++) begin : g_side
        localparam bit NEG_X = (s == 0);
        localparam int T_W   = PROD_W + 3;

        logic [DMAG_W-1:0]   x_hi, x_lo, y_hi, y_lo;
        side_t               m0_next;
        side_t               m0_reg;
        logic [CF_DEN_W-1:0] cfden_next;
        logic [CF_DEN_W-1:0] cfden_reg;
        logic [CF_QUO_W-1:0] cf_quo;
        side_t               dly_reg [CF_QUO_W];
        logic [CF_W-1:0]     corr;
        prod_t               p1_next;
        prod_t               p1_reg;
        logic [T_W-1:0]      tx, ty;
        logic [CEN_NUM_W-1:0] numx_reg, numy_reg;
        logic [WSUM_W-1:0]   den_reg;
        sign_t               sg_reg;
        sign_t               sdly_reg [CEN_QUO_W];
        logic [CEN_QUO_W-1:0] qx_quo, qy_quo;
        logic [Q_W-1:0]      qx_reg, qy_reg;
        logic                zero_reg;

        // Sums and signed differences of the tower pairs
        always_comb
        begin
            x_hi = DMAG_W'(weights[s][1]) + DMAG_W'(weights[s][3]);
            x_lo = DMAG_W'(weights[s][0]) + DMAG_W'(weights[s][2]);
            y_hi = DMAG_W'(weights[s][2]) + DMAG_W'(weights[s][3]);
            y_lo = DMAG_W'(weights[s][0]) + DMAG_W'(weights[s][1]);
            m0_next.wsum = WSUM_W'(x_hi) + WSUM_W'(x_lo);
            m0_next.xmag = (x_hi >= x_lo) ? x_hi - x_lo : x_lo - x_hi;
            m0_next.ymag = (y_hi >= y_lo) ? y_hi - y_lo : y_lo - y_hi;
            m0_next.xneg = NEG_X ? (x_hi > x_lo) : (x_hi < x_lo);
            m0_next.yneg = y_hi < y_lo;
            m0_next.zero = (m0_next.wsum == '0);
            cfden_next   = (CF_DEN_W'(lin_sums[s]) << 8) + CF_DEN_W'(CF_OFS_Q8);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                m0_reg    <= m0_next;
                cfden_reg <= cfden_next;
            end
        end

        zscp_divider #(
            .NUM_W (CF_NUM_W),
            .DEN_W (CF_DEN_W),
            .QUO_W (CF_QUO_W)
        ) u_cf_div (
            .clk (clk),
            .en  (en),
            .num (CF_NUM),
            .den (cfden_reg),
            .quo (cf_quo)
        );

        // Hold side data while the correction factor resolves
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dly_reg[0] <= m0_reg;
                for (int i = 1; i < CF_QUO_W; i++)
                begin
                    dly_reg[i] <= dly_reg[i-1];
                end
            end
        end

        // Correction factor times difference magnitude
        always_comb
        begin
            corr = spectator_correction ? CF_W'(CF_BASE_Q16 - CF_W'(cf_quo)) : ONE_Q16;
            p1_next.px   = PROD_W'(corr) * PROD_W'(dly_reg[CF_QUO_W-1].xmag);
            p1_next.py   = PROD_W'(corr) * PROD_W'(dly_reg[CF_QUO_W-1].ymag);
            p1_next.wsum = dly_reg[CF_QUO_W-1].wsum;
            p1_next.xneg = dly_reg[CF_QUO_W-1].xneg;
            p1_next.yneg = dly_reg[CF_QUO_W-1].yneg;
            p1_next.zero = dly_reg[CF_QUO_W-1].zero;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                p1_reg <= p1_next;
            end
        end

        // Times 7168, plus half the divisor, over 65536 (exact as /64)
        always_comb
        begin
            tx = (T_W'(p1_reg.px) << 3) - T_W'(p1_reg.px) + (T_W'(p1_reg.wsum) << 5);
            ty = (T_W'(p1_reg.py) << 3) - T_W'(p1_reg.py) + (T_W'(p1_reg.wsum) << 5);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                numx_reg    <= tx[CEN_NUM_W+5:6];
                numy_reg    <= ty[CEN_NUM_W+5:6];
                den_reg     <= p1_reg.wsum;
                sg_reg.xneg <= p1_reg.xneg;
                sg_reg.yneg <= p1_reg.yneg;
                sg_reg.zero <= p1_reg.zero;
            end
        end

        zscp_divider #(
            .NUM_W (CEN_NUM_W),
            .DEN_W (WSUM_W),
            .QUO_W (CEN_QUO_W)
        ) u_x_div (
            .clk (clk),
            .en  (en),
            .num (numx_reg),
            .den (den_reg),
            .quo (qx_quo)
        );

        zscp_divider #(
            .NUM_W (CEN_NUM_W),
            .DEN_W (WSUM_W),
            .QUO_W (CEN_QUO_W)
        ) u_y_div (
            .clk (clk),
            .en  (en),
            .num (numy_reg),
            .den (den_reg),
            .quo (qy_quo)
        );

        // Carry signs alongside the divisions, then apply them.
        // The magnitude stays below 2^14 since |difference| <= sum.
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sdly_reg[0] <= sg_reg;
                for (int i = 1; i < CEN_QUO_W; i++)
                begin
                    sdly_reg[i] <= sdly_reg[i-1];
                end
                qx_reg   <= sdly_reg[CEN_QUO_W-1].xneg ? Q_W'(0) - Q_W'(qx_quo) : Q_W'(qx_quo);
                qy_reg   <= sdly_reg[CEN_QUO_W-1].yneg ? Q_W'(0) - Q_W'(qy_quo) : Q_W'(qy_quo);
                zero_reg <= sdly_reg[CEN_QUO_W-1].zero;
            end
        end

        assign result.qx[s] = qx_reg;
        assign result.qy[s] = qy_reg;
        assign zero_out[s]  = zero_reg;
    end

    assign result.sum_zero = |zero_out;

endmodule

[rtl/core/zdc_spectator_plane_centroid_top.sv]
// ----------------------------------------------------------------------------
// zdc_spectator_plane_centroid_top
// Spectator-plane centroid of a zero-degree calorimeter pair.
//
// Channels: evt takes one collision per beat (flags, centrality, vertex z,
// common and sector energies of sides A and C); res gives one beat per
// collision with the accept flag, the reject stage code and the four Q3.12
// centroids (zero on reject); cfg writes one register per beat and is always
// ready. Register writes are meant for an idle block.
// Throughput: one collision per cycle unless the skid register is full. A
// collision passes the 31-stage power-weight lanes (16 squaring steps of
// the log2, 12 constant products of the exp2), then the merge: a 16-stage
// correction-factor divider and a 15-stage centroid divider.
// Eight lanes, one per sector, run side by side; the merge combines them.
// Reset restores the register defaults and empties the pipeline. When the
// receiver stalls, the result waits in the output register, one more beat
// lands in a skid register, and evt.ready drops until the skid drains.
// ----------------------------------------------------------------------------
module zdc_spectator_plane_centroid_top #(
    parameter int ENERGY_BITS = zscp_pkg::ENERGY_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    zscp_stream_if.sink   evt,
    zscp_stream_if.source res,
    zscp_stream_if.sink   cfg
);
    import zscp_pkg::*;

    // Configuration registers
    logic [14:0] vertex_cut_reg;
    logic [13:0] cent_min_reg;
    logic [13:0] cent_max_reg;
    logic        req_quality_reg;
    logic        req_zvtx_reg;
    logic        power_wt_reg;
    logic        spec_corr_reg;

    logic        en;
    logic        accept;

    logic [SIDES-1:0][TOWERS-1:0][MAG_W-1:0]    mag;
    logic [SIDES-1:0][TOWERS-1:0]               pos;
    logic [SIDES-1:0][TOWERS-1:0][WEIGHT_W-1:0] lane_w;
    logic [SIDES-1:0][LSUM_W-1:0]               lin_next;

    logic [16:0] vabs;
    logic        com_ok;
    logic        cuts_ok;
    logic [3:0]  stage_next;

    logic [TOTAL_LAT-1:0] vld_reg;
    logic [3:0]           stage_reg [TOTAL_LAT];
    logic [SIDES-1:0][LSUM_W-1:0] lin_reg [LANE_LAT];

    merge_out_t  mo;
    result_t     tail;
    logic        emit;

    logic        out_valid_reg, out_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    result_t     out_reg, out_next;
    result_t     skid_reg, skid_next;

    // Register writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_cut_reg  <= 15'd2560;
            cent_min_reg    <= 14'd0;
            cent_max_reg    <= 14'd10240;
            req_quality_reg <= 1'b1;
            req_zvtx_reg    <= 1'b0;
            power_wt_reg    <= 1'b1;
            spec_corr_reg   <= 1'b0;
        end
        else if (cfg.valid)
        begin
            case (cfg.data.index)
                CFG_VERTEX_CUT:  vertex_cut_reg  <= cfg.data.value;
                CFG_CENT_MIN:    cent_min_reg    <= cfg.data.value[13:0];
                CFG_CENT_MAX:    cent_max_reg    <= cfg.data.value[13:0];
                CFG_REQ_QUALITY: req_quality_reg <= cfg.data.value[0];
                CFG_REQ_ZVTX:    req_zvtx_reg    <= cfg.data.value[0];
                CFG_POWER_WT:    power_wt_reg    <= cfg.data.value[0];
                CFG_SPEC_CORR:   spec_corr_reg   <= cfg.data.value[0];
                default:         ;
            endcase
        end
    end

    // Pipeline advances unless the skid register is occupied
    assign en        = !skid_valid_reg;
    assign evt.ready = en;
    assign accept    = evt.valid && en;

    // Unpack sector energies
    for (genvar t = 0; t < TOWERS; t++) begin : g_unpack
        logic [LANE_W-1:0] la, lc;
        assign la = evt.data.side_a_sectors[LANE_W*t +: LANE_W];
        assign lc = evt.data.side_c_sectors[LANE_W*t +: LANE_W];
        assign mag[0][t] = MAG_W'(la[ENERGY_BITS-2:0]);
        assign mag[1][t] = MAG_W'(lc[ENERGY_BITS-2:0]);
        assign pos[0][t] = !la[ENERGY_BITS-1] && (|la[ENERGY_BITS-2:0]);
        assign pos[1][t] = !lc[ENERGY_BITS-1] && (|lc[ENERGY_BITS-2:0]);
    end

    // Event checks in priority order, linear sector sums
    always_comb
    begin
        vabs = evt.data.vertex_z[15] ? 17'd0 - {1'b1, evt.data.vertex_z}
                                     : {1'b0, evt.data.vertex_z};
        com_ok = !evt.data.side_a_common[ENERGY_BITS-1]
              && (|evt.data.side_a_common[ENERGY_BITS-2:0])
              && !evt.data.side_c_common[ENERGY_BITS-1]
              && (|evt.data.side_c_common[ENERGY_BITS-2:0]);
        cuts_ok = (&evt.data.event_flags[6:3])
               && (evt.data.centrality > cent_min_reg)
               && (evt.data.centrality < cent_max_reg)
               && (vabs < {2'b00, vertex_cut_reg});
        if (!evt.data.event_flags[0])
            stage_next = RJ_NO_ZDC;
        else if (!com_ok)
            stage_next = RJ_COMMON;
        else if (!(&pos[0]))
            stage_next = RJ_SECTOR_A;
        else if (!(&pos[1]))
            stage_next = RJ_SECTOR_C;
        else if (req_quality_reg && !evt.data.event_flags[1])
            stage_next = RJ_QUALITY;
        else if (req_zvtx_reg && !evt.data.event_flags[2])
            stage_next = RJ_ZVTX;
        else if (!cuts_ok)
            stage_next = RJ_CUTS;
        else
            stage_next = RJ_ACCEPTED;
        for (int s = 0; s < SIDES; s++)
        begin
            lin_next[s] = LSUM_W'(mag[s][0]) + LSUM_W'(mag[s][1])
                        + LSUM_W'(mag[s][2]) + LSUM_W'(mag[s][3]);
        end
    end

    // Sector lanes
    for (genvar s = 0; s < SIDES; s++) begin : g_side
        for (genvar t = 0; t < TOWERS; t++) begin : g_lane
            zscp_power_lane u_lane (
                .clk             (clk),
                .en              (en),
                .power_weighting (power_wt_reg),
                .energy          (mag[s][t]),
                .weight          (lane_w[s][t])
            );
        end
    end

    // Valid line and side data alongside the lanes and merge
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[TOTAL_LAT-2:0], accept};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg[0] <= stage_next;
            for (int i = 1; i < TOTAL_LAT; i++)
            begin
                stage_reg[i] <= stage_reg[i-1];
            end
            lin_reg[0] <= lin_next;
            for (int i = 1; i < LANE_LAT; i++)
            begin
                lin_reg[i] <= lin_reg[i-1];
            end
        end
    end

    zscp_merge u_merge (
        .clk                  (clk),
        .en                   (en),
        .spectator_correction (spec_corr_reg),
        .weights              (lane_w),
        .lin_sums             (lin_reg[LANE_LAT-1]),
        .result               (mo)
    );

    // Assemble the result at the pipeline tail
    always_comb
    begin
        tail = '0;
        if (stage_reg[TOTAL_LAT-1] != RJ_ACCEPTED)
        begin
            tail.reject_stage = stage_reg[TOTAL_LAT-1];
        end
        else if (mo.sum_zero)
        begin
            tail.reject_stage = RJ_SMALL_SUM;
        end
        else
        begin
            tail.accepted     = 1'b1;
            tail.reject_stage = RJ_ACCEPTED;
            tail.side_a_qx    = mo.qx[0];
            tail.side_c_qx    = mo.qx[1];
            tail.side_a_qy    = mo.qy[0];
            tail.side_c_qy    = mo.qy[1];
        end
    end

    assign emit = en && vld_reg[TOTAL_LAT-1];

    // Output register with one skid beat
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (out_valid_reg && !res.ready)
        begin
            if (emit)
            begin
                skid_valid_next = 1'b1;
                skid_next       = tail;
            end
        end
        else if (skid_valid_reg)
        begin
            out_valid_next  = 1'b1;
            out_next        = skid_reg;
            skid_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = emit;
            out_next       = tail;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign res.valid = out_valid_reg;
    assign res.data  = out_reg;

    // Skid holds a beat only behind a waiting output beat
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid occupied while output register empty");

    // Skid fills only from a stalled output
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !res.ready))
        else $error("skid filled without a stall");

    // Accepted beats carry the accepted code
    a_accept_code: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.data.accepted |-> res.data.reject_stage == RJ_ACCEPTED)
        else $error("accepted beat with wrong stage code");

    // Rejected beats carry zero centroids
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.data.accepted |->
            res.data.side_a_qx == 16'sd0 && res.data.side_c_qx == 16'sd0 &&
            res.data.side_a_qy == 16'sd0 && res.data.side_c_qy == 16'sd0)
        else $error("rejected beat with nonzero centroid");

endmodule

[tb/sv/zdc_spectator_plane_centroid_top_tb.sv]
// ----------------------------------------------------------------------------
// zdc_spectator_plane_centroid_top_tb
// Self-checking bench of the spectator-plane centroid block. Collisions are
// queued by a stimulus process and sent by a clocked driver. A clocked monitor
// compares each result beat with the oldest prediction from an in-bench
// model of the reject chain, power weights and centroid arithmetic.
// Phases vary the register settings and the idle and stall rates.
// ----------------------------------------------------------------------------
module zdc_spectator_plane_centroid_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import zscp_pkg::*;

    localparam int PIPE_LAT = 67;

    logic clk;
    logic rst_n;

    zscp_stream_if #(.payload_t(event_t))     evt_if ();
    zscp_stream_if #(.payload_t(result_t))    res_if ();
    zscp_stream_if #(.payload_t(cfg_write_t)) cfg_if ();

    zdc_spectator_plane_centroid_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt_if.sink),
        .res   (res_if.source),
        .cfg   (cfg_if.sink)
    );

    // Shadow of the block's registers
    logic [14:0] sh_vertex_cut;
    logic [13:0] sh_cent_min;
    logic [13:0] sh_cent_max;
    logic        sh_req_quality;
    logic        sh_req_zvtx;
    logic        sh_power_wt;
    logic        sh_spec_corr;

    event_t  pending_events[$];
    result_t expected_results[$];
    cfg_write_t pending_writes[$];

    int send_idle_pct;
    int recv_stall_pct;
    int mismatch_count;
    int result_count;
    int accepted_count;
    int stage_seen[9];
    bit stim_done;

    // Clock
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic signed [31:0] lane_energy(input logic [63:0] packed_e, input int i);
        logic signed [15:0] v;
        v = packed_e[16*i +: 16];
        return 32'(v);
    endfunction

    function automatic logic [63:0] energy_pow(input logic [31:0] e);
        int p;
        logic [63:0] x;
        logic [63:0] l;
        logic [63:0] lp;
        logic [63:0] r;
        p = 0;
        while (p < 15 && (e >> (p + 1)) != 0)
            p++;
        x = 64'(e) << (15 - p);
        l = 64'(p) << 16;
        for (int i = 0; i < 16; i++)
        begin
            x = (x * x) >> 15;
            if (x >= 65536)
            begin
                x = x >> 1;
                l = l | (64'd1 << (15 - i));
            end
        end
        lp = (l * 25887 + 32768) >> 16;
        r = 65536;
        for (int i = 0; i < 12; i++)
            if (lp[15 - i])
                r = (r * 64'(EXP2_FRAC[i]) + 32768) >> 16;
        return r << lp[19:16];
    endfunction

    function automatic logic [15:0] centroid_q(input longint d, input logic [63:0] wsum,
                                               input logic [63:0] c);
        logic [63:0] mag;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] q;
        mag = (d < 0) ? 64'(-d) : 64'(d);
        num = c * 64'd7168 * mag;
        den = wsum << 16;
        q = (num + den / 2) / den;
        if (d < 0)
            return (q > 32768) ? 16'h8000 : 16'(-longint'(q));
        return (q > 32767) ? 16'h7fff : 16'(q);
    endfunction

    // Predict the result of one collision
    function automatic result_t predict_centroids(input event_t ev);
        result_t rs;
        logic [15:0] vabs;
        logic [63:0] wa[4];
        logic [63:0] wc[4];
        logic [63:0] suma, sumc, lina, linc, ca, cc;
        bit pos_a, pos_c;
        rs = '0;
        vabs = ev.vertex_z[15] ? 16'(-ev.vertex_z) : ev.vertex_z;
        pos_a = 1;
        pos_c = 1;
        for (int i = 0; i < 4; i++)
        begin
            if (lane_energy(ev.side_a_sectors, i) <= 0) pos_a = 0;
            if (lane_energy(ev.side_c_sectors, i) <= 0) pos_c = 0;
        end
        if (!ev.event_flags[0]) rs.reject_stage = RJ_NO_ZDC;
        else if (ev.side_a_common <= 0 || ev.side_c_common <= 0) rs.reject_stage = RJ_COMMON;
        else if (!pos_a) rs.reject_stage = RJ_SECTOR_A;
        else if (!pos_c) rs.reject_stage = RJ_SECTOR_C;
        else if (sh_req_quality && !ev.event_flags[1]) rs.reject_stage = RJ_QUALITY;
        else if (sh_req_zvtx && !ev.event_flags[2]) rs.reject_stage = RJ_ZVTX;
        else if (!(&ev.event_flags[6:3] && ev.centrality > sh_cent_min &&
                   ev.centrality < sh_cent_max && vabs < 16'(sh_vertex_cut)))
            rs.reject_stage = RJ_CUTS;
        else
            rs.reject_stage = RJ_ACCEPTED;
        if (rs.reject_stage != RJ_ACCEPTED)
            return rs;
        suma = 0; sumc = 0; lina = 0; linc = 0;
        for (int i = 0; i < 4; i++)
        begin
            wa[i] = sh_power_wt ? energy_pow(lane_energy(ev.side_a_sectors, i))
                                : 64'(lane_energy(ev.side_a_sectors, i));
            wc[i] = sh_power_wt ? energy_pow(lane_energy(ev.side_c_sectors, i))
                                : 64'(lane_energy(ev.side_c_sectors, i));
            suma += wa[i]; sumc += wc[i];
            lina += 64'(lane_energy(ev.side_a_sectors, i));
            linc += 64'(lane_energy(ev.side_c_sectors, i));
        end
        if (suma == 0 || sumc == 0)
        begin
            rs.reject_stage = RJ_SMALL_SUM;
            return rs;
        end
        ca = sh_spec_corr ? 64'd124098 - 64'd2050655330 / (lina * 256 + 31522) : 64'd65536;
        cc = sh_spec_corr ? 64'd124098 - 64'd2050655330 / (linc * 256 + 31522) : 64'd65536;
        rs.accepted = 1'b1;
        rs.side_a_qx = centroid_q(-(longint'(wa[1] + wa[3]) - longint'(wa[0] + wa[2])),
                                  suma, ca);
        rs.side_c_qx = centroid_q(longint'(wc[1] + wc[3]) - longint'(wc[0] + wc[2]), sumc, cc);
        rs.side_a_qy = centroid_q(longint'(wa[2] + wa[3]) - longint'(wa[0] + wa[1]), suma, ca);
        rs.side_c_qy = centroid_q(longint'(wc[2] + wc[3]) - longint'(wc[0] + wc[1]), sumc, cc);
        return rs;
    endfunction

    // Driver: send queued collisions and register writes
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_if.valid <= 1'b0;
            evt_if.data  <= '0;
            cfg_if.valid <= 1'b0;
            cfg_if.data  <= '0;
        end
        else
        begin
            if (evt_if.valid && evt_if.ready)
            begin
                expected_results.push_back(predict_centroids(evt_if.data));
                void'(pending_events.pop_front());
            end
            if (cfg_if.valid && cfg_if.ready)
                void'(pending_writes.pop_front());
            // hold an unaccepted beat, otherwise advance to the queue head
            if (!(evt_if.valid && !evt_if.ready))
            begin
                if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    evt_if.valid <= 1'b1;
                    evt_if.data  <= pending_events[0];
                end
                else
                    evt_if.valid <= 1'b0;
            end
            if (!(cfg_if.valid && !cfg_if.ready))
            begin
                if (pending_writes.size() != 0)
                begin
                    cfg_if.valid <= 1'b1;
                    cfg_if.data  <= pending_writes[0];
                end
                else
                    cfg_if.valid <= 1'b0;
            end
        end
    end

    // Monitor: check each result beat and drive the stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_if.ready <= 1'b0;
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                result_count++;
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("ERROR: unexpected result beat %p", res_if.data);
                end
                else
                begin
                    if (res_if.data !== expected_results[0])
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("ERROR: result %0d expected %p got %p", result_count,
                                     expected_results[0], res_if.data);
                    end
                    if (expected_results[0].reject_stage <= RJ_ACCEPTED)
                        stage_seen[expected_results[0].reject_stage]++;
                    if (expected_results[0].accepted)
                        accepted_count++;
                    void'(expected_results.pop_front());
                end
            end
            res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic wait_idle();
        while (pending_events.size() != 0 || evt_if.valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 5) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        pending_writes.push_back('{index: idx, value: 15'(val)});
        case (idx)
            CFG_VERTEX_CUT:  sh_vertex_cut  = 15'(val);
            CFG_CENT_MIN:    sh_cent_min    = val[13:0];
            CFG_CENT_MAX:    sh_cent_max    = val[13:0];
            CFG_REQ_QUALITY: sh_req_quality = val[0];
            CFG_REQ_ZVTX:    sh_req_zvtx    = val[0];
            CFG_POWER_WT:    sh_power_wt    = val[0];
            CFG_SPEC_CORR:   sh_spec_corr   = val[0];
            default: ;
        endcase
        while (pending_writes.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [63:0] pos_sectors(input int hi);
        logic [63:0] s;
        for (int i = 0; i < 4; i++)
            s[16*i +: 16] = 16'($urandom_range(hi, 1));
        return s;
    endfunction

    // Well-formed collision; passes the checks unless the settings leave no centrality or vertex room
    function automatic event_t good_event();
        event_t ev;
        int top;
        ev.event_flags = 7'h7f;
        ev.centrality = 14'((sh_cent_max > sh_cent_min + 1)
                        ? $urandom_range(sh_cent_max - 1, sh_cent_min + 1) : 0);
        ev.vertex_z = (sh_vertex_cut == 0) ? 16'sd0
                      : 16'(16'($urandom_range(sh_vertex_cut - 1)) *
                            ($urandom_range(1) ? 1 : -1));
        ev.side_a_common = 16'($urandom_range(32767, 1));
        ev.side_c_common = 16'($urandom_range(32767, 1));
        top = ($urandom_range(3) == 0) ? 32767 : (($urandom_range(1)) ? 4095 : 63);
        ev.side_a_sectors = pos_sectors(top);
        ev.side_c_sectors = pos_sectors(top);
        return ev;
    endfunction

    function automatic event_t random_event();
        event_t ev;
        ev = good_event();
        case ($urandom_range(9))
            0: ev = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            1: ev.event_flags = 7'($urandom);
            2: ev.side_a_common = 16'($urandom);
            3: ev.side_c_sectors[16*$urandom_range(3) +: 16] = 16'($urandom);
            4: ev.side_a_sectors[16*$urandom_range(3) +: 16] = 16'($urandom);
            5: ev.vertex_z = 16'($urandom);
            6: ev.centrality = 14'($urandom_range(16383));
            default: ;
        endcase
        ev.event_flags[0] = ev.event_flags[0] | ($urandom_range(7) != 0);
        return ev;
    endfunction

    // Stimulus
    initial
    begin
        event_t ev;
        rst_n = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        mismatch_count = 0;
        result_count = 0;
        accepted_count = 0;
        stim_done = 0;
        res_if.ready = 1'b0;
        evt_if.valid = 1'b0;
        evt_if.data = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data = '0;
        sh_vertex_cut = 15'd2560;
        sh_cent_min = 14'd0;
        sh_cent_max = 14'd10240;
        sh_req_quality = 1'b1;
        sh_req_zvtx = 1'b0;
        sh_power_wt = 1'b1;
        sh_spec_corr = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reject stages in order and field extremes
        ev = good_event(); ev.event_flags = 7'h7e; pending_events.push_back(ev);
        ev = good_event(); ev.side_a_common = 16'sd0; pending_events.push_back(ev);
        ev = good_event(); ev.side_c_common = -16'sd32768; pending_events.push_back(ev);
        ev = good_event(); ev.side_a_sectors[31:16] = 16'h8000; pending_events.push_back(ev);
        ev = good_event(); ev.side_c_sectors[63:48] = 16'h0000; pending_events.push_back(ev);
        ev = good_event(); ev.event_flags[1] = 1'b0; pending_events.push_back(ev);
        ev = good_event(); ev.event_flags[2] = 1'b0; pending_events.push_back(ev);
        for (int b = 3; b < 7; b++)
        begin
            ev = good_event(); ev.event_flags[b] = 1'b0; pending_events.push_back(ev);
        end
        ev = good_event(); ev.vertex_z = -16'sd32768; pending_events.push_back(ev);
        ev = good_event(); ev.vertex_z = 16'sd32767; pending_events.push_back(ev);
        ev = good_event(); ev.centrality = 14'd0; pending_events.push_back(ev);
        ev = good_event(); ev.centrality = 14'd10240; pending_events.push_back(ev);
        ev = good_event(); ev.centrality = 14'h3fff; pending_events.push_back(ev);
        ev = good_event(); ev.side_a_sectors = {4{16'h7fff}};
        ev.side_c_sectors = {4{16'h0001}}; pending_events.push_back(ev);
        ev = good_event(); ev.side_a_sectors = {16'h7fff, 16'h0001, 16'h0001, 16'h0001};
        ev.side_c_sectors = {16'h0001, 16'h7fff, 16'h7fff, 16'h7fff}; pending_events.push_back(ev);
        ev = good_event(); ev.side_a_common = 16'sd32767; ev.side_c_common = 16'sd1;
        ev.vertex_z = 16'sd2559; pending_events.push_back(ev);
        ev = good_event(); ev.vertex_z = -16'sd2560; pending_events.push_back(ev);
        wait_idle();

        // Random phases over register settings and idle rates
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                1: begin write_reg(CFG_SPEC_CORR, 1); write_reg(CFG_REQ_ZVTX, 1); end
                2: begin write_reg(CFG_POWER_WT, 0); write_reg(CFG_REQ_QUALITY, 0); end
                3: begin write_reg(CFG_VERTEX_CUT, 15'h7fff); write_reg(CFG_CENT_MIN, 0);
                         write_reg(CFG_CENT_MAX, 12800); end
                4: begin write_reg(CFG_POWER_WT, 1); write_reg(CFG_SPEC_CORR, 0);
                         write_reg(CFG_CENT_MIN, 12800); end
                5: begin write_reg(CFG_CENT_MIN, 6000); write_reg(CFG_CENT_MAX, 6400);
                         write_reg(CFG_VERTEX_CUT, 0); write_reg(CFG_REQ_ZVTX, 0); end
                6: begin write_reg(CFG_VERTEX_CUT, 512); write_reg(CFG_CENT_MIN, 0);
                         write_reg(CFG_REQ_QUALITY, 1); write_reg(CFG_SPEC_CORR, 1);
                         write_reg(3'd7, 15'h7fff); end
                7: begin write_reg(CFG_VERTEX_CUT, 2560); write_reg(CFG_CENT_MAX, 10240); end
                default: ;
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            for (int n = 0; n < 116; n++)
            begin
                pending_events.push_back(($urandom_range(2) == 0) ? random_event()
                                                                   : good_event());
                // pause sender until everything has drained
                if (n == 60 && ph == 3)
                    while (pending_events.size() != 0 || evt_if.valid ||
                           expected_results.size() != 0)
                        @(posedge clk);
            end
            wait_idle();
        end
        stim_done = 1;
        $display("Covered %0d results, %0d accepted; reject stages 0..6: %0d %0d %0d %0d %0d %0d %0d",
                 result_count, accepted_count, stage_seen[0], stage_seen[1], stage_seen[2],
                 stage_seen[3], stage_seen[4], stage_seen[5], stage_seen[6]);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("zdc_spectator_plane_centroid_top_tb OK");
        else
            $display("zdc_spectator_plane_centroid_top_tb NOT OK");
        $finish;
    end

    // Watchdog
    initial
    begin
        #4ms;
        $display("zdc_spectator_plane_centroid_top_tb NOT OK");
        $finish;
    end
endmodule
